// ===== rtl/refcounted_ring_slot_allocator_defines.svh =====
// assertion macros for the ring slot allocator checker
// expects signals named clk and rst_n in the scope of use
`ifndef REFCOUNTED_RING_SLOT_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_RING_SLOT_ALLOCATOR_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RRSA_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define RRSA_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rrsa_pkg.sv =====
// shared constants, codes and control types of the ring slot allocator
// no dependencies
package rrsa_pkg;

  localparam int MAX_SLOTS  = 256;
  localparam int COUNT_BITS = 8;
  localparam int SLOT_BITS  = $clog2(MAX_SLOTS);
  localparam int LEN_BITS   = $clog2(MAX_SLOTS + 1);

  localparam int OFF_W      = 31;
  localparam int ITEM_W     = 16;
  localparam int HDR_W      = 16;
  localparam int CFG_LEN_W  = 9;
  localparam int STRIDE_W   = ITEM_W + 1;
  localparam int STATUS_W   = 3;
  localparam int SIDX_W     = 8;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int DIV_CNT_W  = $clog2(OFF_W + 1);
  localparam int PROD_W     = STRIDE_W + SLOT_BITS;

  // per-slot counter word in front of the payload
  localparam int SLOT_HDR_BYTES = 4;

  localparam int ITEM_BYTES_RST   = 64;
  localparam int SLOTS_IN_USE_RST = 256;
  localparam int HEADER_BYTES_RST = 64;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_SHARE   = 2'd1,
    KIND_DEALLOC = 2'd2
  } rrsa_kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_DONE    = 3'd0,
    STS_FULL    = 3'd1,
    STS_EMPTY   = 3'd2,
    STS_REFD    = 3'd3,
    STS_NOTUSED = 3'd4
  } rrsa_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ITEM_BYTES   = 2'd0,
    REG_SLOTS_IN_USE = 2'd1,
    REG_HEADER_BYTES = 2'd2
  } rrsa_reg_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_DIV,
    S_MUL,
    S_ALLOC,
    S_READ,
    S_UPDATE,
    S_FIN
  } rrsa_state_t;

  typedef struct packed {
    logic load;
    logic dispatch;
    logic div_start;
    logic mul;
    logic alloc_wr;
    logic rd;
    logic upd;
    logic fin;
  } rrsa_cmd_t;

  typedef struct packed {
    rrsa_kind_t kind;
    logic       full;
    logic       below_hdr;
    logic       div_last;
    logic       out_free;
  } rrsa_stat_t;

endpackage

// ===== rtl/rrsa_if.sv =====
// request, result and configuration channel interfaces
// depends on rrsa_pkg
interface rrsa_req_if;
  logic                        valid;
  logic                        ready;
  logic [rrsa_pkg::KIND_W-1:0] kind;
  logic [rrsa_pkg::OFF_W-1:0]  slot_offset;

  modport source (output valid, kind, slot_offset, input ready);
  modport sink (input valid, kind, slot_offset, output ready);
endinterface

interface rrsa_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rrsa_pkg::STATUS_W-1:0] status;
  logic [rrsa_pkg::OFF_W-1:0]    given_offset;
  logic [rrsa_pkg::SIDX_W-1:0]   slot_index;

  modport source (output valid, status, given_offset, slot_index, input ready);
  modport sink (input valid, status, given_offset, slot_index, output ready);
endinterface

interface rrsa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [rrsa_pkg::CFG_IDX_W-1:0]  index;
  logic [rrsa_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/rrsa_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module rrsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rrsa_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on rrsa_pkg
module rrsa_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [rrsa_pkg::OFF_W-1:0]    dividend,
  input  logic [rrsa_pkg::STRIDE_W-1:0] divisor,
  output logic                          last,
  output logic [rrsa_pkg::OFF_W-1:0]    quot,
  output logic [rrsa_pkg::STRIDE_W-1:0] rem
);

  logic                           busy_r, busy_nxt;
  logic [rrsa_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [rrsa_pkg::OFF_W-1:0]     dq_r, dq_nxt;
  logic [rrsa_pkg::STRIDE_W-1:0]  rem_r, rem_nxt;
  logic [rrsa_pkg::STRIDE_W-1:0]  dvs_r, dvs_nxt;
  logic [rrsa_pkg::STRIDE_W:0]    trial;
  logic                           ge;

  // shifted partial remainder against the divisor
  assign trial = {rem_r, dq_r[rrsa_pkg::OFF_W-1]};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dq_nxt   = dq_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = rrsa_pkg::DIV_CNT_W'(rrsa_pkg::OFF_W);
      dq_nxt   = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt  = ge ? rrsa_pkg::STRIDE_W'(trial - {1'b0, dvs_r})
                    : rrsa_pkg::STRIDE_W'(trial);
      dq_nxt   = {dq_r[rrsa_pkg::OFF_W-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = (cnt_r != rrsa_pkg::DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dq_r  <= dq_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign last = busy_r && (cnt_r == rrsa_pkg::DIV_CNT_W'(1));
  assign quot = dq_r;
  assign rem  = rem_r;

endmodule

// ===== rtl/rrsa_dp.sv =====
// allocator datapath: registers, ring state, counter ram, divider, result register
// depends on rrsa_pkg, rrsa_ram, rrsa_div
module rrsa_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  rrsa_pkg::rrsa_cmd_t             cmd,
  output rrsa_pkg::rrsa_stat_t            stat,
  input  logic [rrsa_pkg::KIND_W-1:0]     in_kind,
  input  logic [rrsa_pkg::OFF_W-1:0]      in_slot_offset,
  input  logic                            cfg_we,
  input  logic [rrsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rrsa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [rrsa_pkg::STATUS_W-1:0]   out_status,
  output logic [rrsa_pkg::OFF_W-1:0]      out_given_offset,
  output logic [rrsa_pkg::SIDX_W-1:0]     out_slot_index
);

  // configuration
  logic [rrsa_pkg::ITEM_W-1:0]    item_bytes_r;
  logic [rrsa_pkg::CFG_LEN_W-1:0] slots_in_use_r;
  logic [rrsa_pkg::HDR_W-1:0]     header_bytes_r;

  // ring state
  logic [rrsa_pkg::SLOT_BITS-1:0] oldest_r, oldest_nxt;
  logic [rrsa_pkg::LEN_BITS-1:0]  used_r, used_nxt;
  logic [rrsa_pkg::MAX_SLOTS-1:0] cnt_valid_r;

  // request and intermediate values
  logic [rrsa_pkg::KIND_W-1:0]    kind_r;
  logic [rrsa_pkg::OFF_W-1:0]     off_r;
  logic [rrsa_pkg::PROD_W-1:0]    prod_r;
  logic                           vbit_r;

  // pending result and output register
  rrsa_pkg::rrsa_status_t         res_status_r;
  logic [rrsa_pkg::OFF_W-1:0]     res_given_r;
  logic [rrsa_pkg::SIDX_W-1:0]    res_sidx_r;
  logic                           out_valid_r;
  rrsa_pkg::rrsa_status_t         out_status_r;
  logic [rrsa_pkg::OFF_W-1:0]     out_given_r;
  logic [rrsa_pkg::SIDX_W-1:0]    out_sidx_r;

  logic [rrsa_pkg::LEN_BITS-1:0]   ring;
  logic [rrsa_pkg::STRIDE_W-1:0]   stride;
  logic [rrsa_pkg::LEN_BITS:0]     run_end;
  logic [rrsa_pkg::OFF_W-1:0]      diff;
  logic                            is_alloc;
  logic                            full;
  logic                            empty;
  logic                            below_hdr;
  logic [rrsa_pkg::OFF_W-1:0]      div_dividend;
  logic [rrsa_pkg::STRIDE_W-1:0]   div_divisor;
  logic                            div_last;
  logic [rrsa_pkg::OFF_W-1:0]      quot;
  logic [rrsa_pkg::STRIDE_W-1:0]   rem;
  logic [rrsa_pkg::SLOT_BITS-1:0]  q_slot;
  logic [rrsa_pkg::SLOT_BITS-1:0]  fwd_slot;
  logic                            q_valid;
  logic [31:0]                     given_calc;
  logic [rrsa_pkg::COUNT_BITS-1:0] rdata;
  logic [rrsa_pkg::COUNT_BITS-1:0] cnt;
  logic [rrsa_pkg::COUNT_BITS-1:0] cnt_inc;
  logic [rrsa_pkg::COUNT_BITS-1:0] cnt_dec;
  logic [rrsa_pkg::COUNT_BITS-1:0] upd_cnt;
  logic [rrsa_pkg::LEN_BITS:0]     e_pos;
  logic [rrsa_pkg::LEN_BITS-1:0]   q_inc;
  logic                            upd_write;
  logic                            upd_release;
  rrsa_pkg::rrsa_status_t          upd_status;
  rrsa_pkg::rrsa_status_t          early_status;
  logic                            ram_we;
  logic [rrsa_pkg::SLOT_BITS-1:0]  ram_waddr;
  logic [rrsa_pkg::COUNT_BITS-1:0] ram_wdata;

  // ring length clamped to 1 .. MAX_SLOTS
  always_comb begin
    if (slots_in_use_r == '0) begin
      ring = rrsa_pkg::LEN_BITS'(1);
    end else if (32'(slots_in_use_r) > 32'(rrsa_pkg::MAX_SLOTS)) begin
      ring = rrsa_pkg::LEN_BITS'(rrsa_pkg::MAX_SLOTS);
    end else begin
      ring = rrsa_pkg::LEN_BITS'(slots_in_use_r);
    end
  end

  assign stride    = {1'b0, item_bytes_r} + rrsa_pkg::STRIDE_W'(rrsa_pkg::SLOT_HDR_BYTES);
  assign run_end   = (rrsa_pkg::LEN_BITS+1)'(oldest_r) + (rrsa_pkg::LEN_BITS+1)'(used_r);
  assign diff      = off_r - rrsa_pkg::OFF_W'(header_bytes_r);
  assign is_alloc  = (kind_r == rrsa_pkg::KIND_ALLOC);
  assign full      = (used_r >= ring);
  assign empty     = (used_r == '0);
  assign below_hdr = (off_r < rrsa_pkg::OFF_W'(header_bytes_r));

  // the divider is shared: slot lookup by stride, or ring position modulo length
  assign div_dividend = is_alloc ? rrsa_pkg::OFF_W'(run_end) : diff;
  assign div_divisor  = is_alloc ? rrsa_pkg::STRIDE_W'(ring) : stride;

  rrsa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .last     (div_last),
    .quot     (quot),
    .rem      (rem)
  );

  assign q_slot     = quot[rrsa_pkg::SLOT_BITS-1:0];
  assign fwd_slot   = rem[rrsa_pkg::SLOT_BITS-1:0];
  assign q_valid    = (quot < rrsa_pkg::OFF_W'(ring));
  assign given_calc = 32'(header_bytes_r) + 32'(rrsa_pkg::SLOT_HDR_BYTES) + 32'(prod_r);

  // counters never written since reset read as zero
  assign cnt     = vbit_r ? rdata : '0;
  assign cnt_inc = (cnt != rrsa_pkg::COUNT_MAX) ? cnt + 1'b1 : cnt;
  assign cnt_dec = (cnt != '0) ? cnt - 1'b1 : cnt;

  // slot position along the run, unwrapped past the oldest slot
  assign e_pos = (rrsa_pkg::LEN_BITS+1)'(q_slot)
               + ((oldest_r > q_slot) ? (rrsa_pkg::LEN_BITS+1)'(ring) : '0);
  assign q_inc = rrsa_pkg::LEN_BITS'(q_slot) + 1'b1;

  always_comb begin
    upd_status  = rrsa_pkg::STS_NOTUSED;
    upd_write   = 1'b0;
    upd_release = 1'b0;
    upd_cnt     = cnt_dec;
    case (rrsa_pkg::rrsa_kind_t'(kind_r))
      rrsa_pkg::KIND_SHARE: begin
        upd_cnt = cnt_inc;
        if (q_valid) begin
          upd_write  = 1'b1;
          upd_status = rrsa_pkg::STS_DONE;
        end
      end
      rrsa_pkg::KIND_DEALLOC: begin
        if (empty) begin
          upd_status = rrsa_pkg::STS_EMPTY;
        end else if (q_valid) begin
          upd_write = 1'b1;
          if (cnt_dec != '0) begin
            upd_status = rrsa_pkg::STS_REFD;
          end else if (e_pos < run_end) begin
            upd_release = 1'b1;
            upd_status  = rrsa_pkg::STS_DONE;
          end
        end
      end
      default: begin
        upd_status = rrsa_pkg::STS_NOTUSED;
      end
    endcase
  end

  // result of requests that end without a lookup
  always_comb begin
    case (rrsa_pkg::rrsa_kind_t'(kind_r))
      rrsa_pkg::KIND_ALLOC:   early_status = rrsa_pkg::STS_FULL;
      rrsa_pkg::KIND_SHARE:   early_status = rrsa_pkg::STS_NOTUSED;
      rrsa_pkg::KIND_DEALLOC: early_status = empty ? rrsa_pkg::STS_EMPTY
                                                   : rrsa_pkg::STS_NOTUSED;
      default:                early_status = rrsa_pkg::STS_NOTUSED;
    endcase
  end

  assign ram_we    = cmd.alloc_wr || (cmd.upd && upd_write);
  assign ram_waddr = cmd.alloc_wr ? fwd_slot : q_slot;
  assign ram_wdata = cmd.alloc_wr ? rrsa_pkg::COUNT_BITS'(1) : upd_cnt;

  rrsa_ram #(
    .WIDTH (rrsa_pkg::COUNT_BITS),
    .DEPTH (rrsa_pkg::MAX_SLOTS)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (q_slot),
    .rdata (rdata)
  );

  always_comb begin
    oldest_nxt = oldest_r;
    used_nxt   = used_r;
    if (cmd.alloc_wr) begin
      used_nxt = used_r + 1'b1;
    end else if (cmd.upd && upd_release) begin
      used_nxt   = rrsa_pkg::LEN_BITS'(run_end - e_pos - 1'b1);
      oldest_nxt = (q_inc == ring) ? '0 : q_inc[rrsa_pkg::SLOT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_bytes_r   <= rrsa_pkg::ITEM_W'(rrsa_pkg::ITEM_BYTES_RST);
      slots_in_use_r <= rrsa_pkg::CFG_LEN_W'(rrsa_pkg::SLOTS_IN_USE_RST);
      header_bytes_r <= rrsa_pkg::HDR_W'(rrsa_pkg::HEADER_BYTES_RST);
      oldest_r       <= '0;
      used_r         <= '0;
      cnt_valid_r    <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (rrsa_pkg::rrsa_reg_t'(cfg_index))
          rrsa_pkg::REG_ITEM_BYTES:   item_bytes_r   <= rrsa_pkg::ITEM_W'(cfg_data);
          rrsa_pkg::REG_SLOTS_IN_USE: slots_in_use_r <= rrsa_pkg::CFG_LEN_W'(cfg_data);
          rrsa_pkg::REG_HEADER_BYTES: header_bytes_r <= rrsa_pkg::HDR_W'(cfg_data);
          default: ;
        endcase
      end
      oldest_r <= oldest_nxt;
      used_r   <= used_nxt;
      if (ram_we) begin
        cnt_valid_r[ram_waddr] <= 1'b1;
      end
      if (cmd.fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      off_r  <= in_slot_offset;
    end
    if (cmd.mul) begin
      prod_r <= stride * fwd_slot;
    end
    if (cmd.rd) begin
      vbit_r <= cnt_valid_r[q_slot];
    end
    if (cmd.dispatch) begin
      res_status_r <= early_status;
      res_given_r  <= '0;
      res_sidx_r   <= '0;
    end else if (cmd.alloc_wr) begin
      res_status_r <= rrsa_pkg::STS_DONE;
      res_given_r  <= given_calc[rrsa_pkg::OFF_W-1:0];
      res_sidx_r   <= rrsa_pkg::SIDX_W'(fwd_slot);
    end else if (cmd.upd) begin
      res_status_r <= upd_status;
      res_given_r  <= '0;
      res_sidx_r   <= quot[rrsa_pkg::SIDX_W-1:0];
    end
    if (cmd.fin) begin
      out_status_r <= res_status_r;
      out_given_r  <= res_given_r;
      out_sidx_r   <= res_sidx_r;
    end
  end

  assign stat.kind      = rrsa_pkg::rrsa_kind_t'(kind_r);
  assign stat.full      = full;
  assign stat.below_hdr = below_hdr;
  assign stat.div_last  = div_last;
  assign stat.out_free  = !out_valid_r || out_ready;

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_given_offset = out_given_r;
  assign out_slot_index   = out_sidx_r;

endmodule

// ===== rtl/rrsa_ctrl.sv =====
// allocator sequencer: one request at a time through lookup and counter update
// depends on rrsa_pkg
module rrsa_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  rrsa_pkg::rrsa_stat_t  stat,
  output rrsa_pkg::rrsa_cmd_t   cmd
);

  rrsa_pkg::rrsa_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rrsa_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      rrsa_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = rrsa_pkg::S_DISPATCH;
        end
      end
      rrsa_pkg::S_DISPATCH: begin
        cmd.dispatch = 1'b1;
        case (stat.kind)
          rrsa_pkg::KIND_ALLOC: begin
            if (stat.full) begin
              state_nxt = rrsa_pkg::S_FIN;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = rrsa_pkg::S_DIV;
            end
          end
          rrsa_pkg::KIND_SHARE, rrsa_pkg::KIND_DEALLOC: begin
            if (stat.below_hdr) begin
              state_nxt = rrsa_pkg::S_FIN;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = rrsa_pkg::S_DIV;
            end
          end
          default: begin
            state_nxt = rrsa_pkg::S_FIN;
          end
        endcase
      end
      rrsa_pkg::S_DIV: begin
        if (stat.div_last) begin
          state_nxt = (stat.kind == rrsa_pkg::KIND_ALLOC) ? rrsa_pkg::S_MUL
                                                          : rrsa_pkg::S_READ;
        end
      end
      rrsa_pkg::S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = rrsa_pkg::S_ALLOC;
      end
      rrsa_pkg::S_ALLOC: begin
        cmd.alloc_wr = 1'b1;
        state_nxt    = rrsa_pkg::S_FIN;
      end
      rrsa_pkg::S_READ: begin
        cmd.rd    = 1'b1;
        state_nxt = rrsa_pkg::S_UPDATE;
      end
      rrsa_pkg::S_UPDATE: begin
        cmd.upd   = 1'b1;
        state_nxt = rrsa_pkg::S_FIN;
      end
      rrsa_pkg::S_FIN: begin
        if (stat.out_free) begin
          cmd.fin   = 1'b1;
          state_nxt = rrsa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = rrsa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/refcounted_ring_slot_allocator.sv =====
// top level of the reference-counted ring slot allocator
// depends on rrsa_pkg, rrsa_if, rrsa_ctrl, rrsa_dp
//
// Ring of fixed-size slots with a per-slot reference counter. Slot k sits at byte
// offset header_bytes + 4 + (item_bytes + 4) * k. Allocate takes the slot after the
// used run, sets its count to 1 and returns the offset; share maps an offset back to
// a slot and bumps its count (saturating); deallocate drops the count and, once it
// reaches zero inside the used run, releases that slot and every older one. Each
// request yields exactly one result. Requests are handled one at a time: a request
// that needs a lookup goes from dispatch through the 31-step restoring divider (one
// quotient bit per cycle) that turns an offset into a slot index, or for allocate
// reduces the ring position modulo the ring length, then through multiply or
// counter read, counter write and finish to the result register; the next request
// is taken once the sequencer is idle again. Allocate on a full ring, share or
// deallocate below the header, and unknown kinds go from dispatch straight to
// finish. A finished result sits in an output register, so the next request is
// accepted while the previous result waits to be taken; a result waiting there
// holds the finish step of the following request. Counters are held in a 256-entry
// ram with a valid bit per entry that reset clears, so the block is ready right
// after reset. Configuration writes are always accepted and must only be issued
// while no request is in flight.
module refcounted_ring_slot_allocator (
  input  logic       clk,
  input  logic       rst_n,
  rrsa_req_if.sink   in_req,
  rrsa_rsp_if.source out_rsp,
  rrsa_cfg_if.sink   cfg_wr
);

  rrsa_pkg::rrsa_cmd_t  cmd;
  rrsa_pkg::rrsa_stat_t stat;

  // configuration registers take a write every cycle
  assign cfg_wr.ready = 1'b1;

  // sequencer: accepts a request only when idle
  rrsa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // ring state, counter ram, divider and result register
  rrsa_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_kind          (in_req.kind),
    .in_slot_offset   (in_req.slot_offset),
    .cfg_we           (cfg_wr.valid),
    .cfg_index        (cfg_wr.index),
    .cfg_data         (cfg_wr.data),
    .out_ready        (out_rsp.ready),
    .out_valid        (out_rsp.valid),
    .out_status       (out_rsp.status),
    .out_given_offset (out_rsp.given_offset),
    .out_slot_index   (out_rsp.slot_index)
  );

endmodule

// ===== rtl/rrsa_checker.sv =====
// port-level checks of the ring slot allocator, bound to the top level
// depends on rrsa_pkg and refcounted_ring_slot_allocator_defines.svh
`include "refcounted_ring_slot_allocator_defines.svh"

module rrsa_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [rrsa_pkg::STATUS_W-1:0] out_status,
  input logic [rrsa_pkg::OFF_W-1:0]    out_given_offset,
  input logic [rrsa_pkg::SIDX_W-1:0]   out_slot_index
);

  // one request in flight: no back-to-back acceptance
  `RRSA_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready, "request accepted while busy")

  // stalled result holds its payload
  `RRSA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_given_offset) && $stable(out_slot_index), "stalled result changed")

  // an offset is only handed out on success
  `RRSA_ASSERT_IMP(a_offset_on_done, out_valid && out_status != rrsa_pkg::STS_DONE, out_given_offset == '0, "offset given on failed request")

  // full ring reports no slot
  `RRSA_ASSERT_IMP(a_full_no_slot, out_valid && out_status == rrsa_pkg::STS_FULL, out_slot_index == '0, "slot index on full ring")

endmodule

bind refcounted_ring_slot_allocator rrsa_checker u_rrsa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_req.valid),
  .in_ready         (in_req.ready),
  .out_valid        (out_rsp.valid),
  .out_ready        (out_rsp.ready),
  .out_status       (out_rsp.status),
  .out_given_offset (out_rsp.given_offset),
  .out_slot_index   (out_rsp.slot_index)
);

// ===== tb/sv/ring_slot_checker.sv =====
// result checker for the ring slot allocator: predicts every accepted request
// depends on rrsa_pkg and the channel interfaces in rrsa_if
module ring_slot_checker
  import rrsa_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  rrsa_req_if                  req,
  rrsa_rsp_if                  rsp,
  rrsa_cfg_if                  cfg,
  output int                   fail_count,
  output int                   pending,
  output logic [SLOT_BITS-1:0] run_oldest,
  output logic [LEN_BITS-1:0]  run_used
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    rrsa_status_t      status;
    logic [OFF_W-1:0]  given_offset;
    logic [SIDX_W-1:0] slot_index;
  } slot_result_t;

  logic [ITEM_W-1:0]     item_bytes;
  logic [CFG_LEN_W-1:0]  ring_reg;
  logic [HDR_W-1:0]      header_bytes;
  logic [SLOT_BITS-1:0]  oldest_slot;
  logic [LEN_BITS-1:0]   used_slots;
  logic [COUNT_BITS-1:0] slot_refs [MAX_SLOTS];
  slot_result_t          expected_results [$];
  slot_result_t          want;

  function automatic slot_result_t predict_slot_result(logic [KIND_W-1:0] kind,
                                                        logic [OFF_W-1:0] off);
    slot_result_t r;
    int unsigned  ring, stride, fwd, q, e, run_end;
    bit           in_ring;
    r.status       = STS_NOTUSED;
    r.given_offset = '0;
    r.slot_index   = '0;
    ring    = (ring_reg == 0) ? 1 : ((ring_reg > MAX_SLOTS) ? MAX_SLOTS : ring_reg);
    stride  = item_bytes + SLOT_HDR_BYTES;
    in_ring = 1'b0;
    q       = 0;
    // offset to slot lookup, only for share and deallocate
    if ((kind == KIND_SHARE || kind == KIND_DEALLOC) && off >= header_bytes) begin
      q            = (off - header_bytes) / stride;
      in_ring      = q < ring;
      r.slot_index = q[SIDX_W-1:0];
    end
    case (kind)
      KIND_ALLOC: begin
        if (used_slots >= ring) begin
          r.status = STS_FULL;
        end else begin
          fwd            = (oldest_slot + used_slots) % ring;
          r.given_offset = OFF_W'(header_bytes + SLOT_HDR_BYTES + stride * fwd);
          slot_refs[fwd] = COUNT_BITS'(1);
          used_slots     = LEN_BITS'(used_slots + 1);
          r.slot_index   = fwd[SIDX_W-1:0];
          r.status       = STS_DONE;
        end
      end
      KIND_SHARE: begin
        if (in_ring) begin
          if (slot_refs[q] != COUNT_MAX) slot_refs[q] = slot_refs[q] + 1'b1;
          r.status = STS_DONE;
        end
      end
      KIND_DEALLOC: begin
        if (used_slots == 0) begin
          r.status = STS_EMPTY;
        end else if (in_ring) begin
          if (slot_refs[q] != 0) slot_refs[q] = slot_refs[q] - 1'b1;
          if (slot_refs[q] != 0) begin
            r.status = STS_REFD;
          end else begin
            // release the slot and everything older when it lies in the run
            e       = (q < oldest_slot) ? q + ring : q;
            run_end = oldest_slot + used_slots;
            if (e < run_end) begin
              used_slots  = LEN_BITS'(run_end - e - 1);
              oldest_slot = SLOT_BITS'((e + 1) % ring);
              r.status    = STS_DONE;
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      item_bytes   = ITEM_W'(ITEM_BYTES_RST);
      ring_reg     = CFG_LEN_W'(SLOTS_IN_USE_RST);
      header_bytes = HDR_W'(HEADER_BYTES_RST);
      oldest_slot  = '0;
      used_slots   = '0;
      foreach (slot_refs[i]) slot_refs[i] = '0;
      expected_results.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_ITEM_BYTES:   item_bytes = cfg.data;
          REG_SLOTS_IN_USE: ring_reg = cfg.data[CFG_LEN_W-1:0];
          REG_HEADER_BYTES: header_bytes = cfg.data;
          default: ;
        endcase
      end
      // a result never leaves in the cycle its request is accepted, so compare first
      if (rsp.valid && rsp.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d given_offset %0d slot_index %0d",
                 rsp.status, rsp.given_offset, rsp.slot_index);
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp.status);
            fail_count++;
          end
          if (rsp.given_offset !== want.given_offset) begin
            $error("given_offset: expected %0d, actual %0d", want.given_offset,
                   rsp.given_offset);
            fail_count++;
          end
          if (rsp.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, actual %0d", want.slot_index, rsp.slot_index);
            fail_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        expected_results.push_back(predict_slot_result(req.kind, req.slot_offset));
      end
    end
    pending    <= expected_results.size();
    run_oldest <= oldest_slot;
    run_used   <= used_slots;
  end

endmodule

// ===== tb/sv/testbench.sv =====
// top of the ring slot allocator testbench: clock, reset, request stimulus, verdict
// depends on rrsa_pkg, rrsa_if, the allocator RTL and ring_slot_checker
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rrsa_pkg::*;

  // codes that the package enums leave out
  localparam logic [KIND_W-1:0]    KIND_RSVD = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RSVD  = 2'd3;

  // the quiet limit covers a lookup, both idle bursts and the settle time several
  // times over
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 150;
  localparam int RANDOM_PHASE   = 6;
  localparam int SAT_SHARES     = 257;

  // per-phase register settings: extremes, clamped ring lengths, small rings
  localparam logic [15:0] PHASE_ITEM [PHASES] = '{64, 0, 65535, 12, 0, 300, 0, 20};
  localparam logic [8:0]  PHASE_LEN  [PHASES] = '{4, 1, 256, 8, 0, 511, 0, 3};
  localparam logic [15:0] PHASE_HDR  [PHASES] = '{64, 0, 65535, 100, 7, 3, 0, 65535};

  logic clk = 1'b0;
  logic rst_n;

  rrsa_req_if req_ch ();
  rrsa_rsp_if rsp_ch ();
  rrsa_cfg_if cfg_ch ();

  int                   fail_count;
  int                   pending;
  logic [SLOT_BITS-1:0] run_oldest;
  logic [LEN_BITS-1:0]  run_used;

  // current register view, used only to aim offsets at real slots
  int unsigned cur_item = ITEM_BYTES_RST;
  int unsigned cur_ring = SLOTS_IN_USE_RST;
  int unsigned cur_hdr  = HEADER_BYTES_RST;

  bit src_gaps    = 1'b1;
  bit sink_stalls = 1'b1;

  refcounted_ring_slot_allocator DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch),
    .cfg_wr  (cfg_ch)
  );

  ring_slot_checker slot_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .cfg        (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending),
    .run_oldest (run_oldest),
    .run_used   (run_used)
  );

  always #2 clk = ~clk;

  // result side back-pressure: random stalls
  logic        sink_ready = 1'b0;
  int unsigned stall_left = 0;
  assign rsp_ch.ready = sink_ready;

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      sink_ready <= (stall_left == 1);
    end else if (sink_stalls && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 14);
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // watchdog: too long without any handshake means the block hung
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // byte offset of a slot under the current settings; anywhere picks a random
  // byte inside the slot, which still maps back to the same index
  function automatic logic [OFF_W-1:0] offset_of(int unsigned slot, bit anywhere);
    longint unsigned stride, pos;
    stride = cur_item + SLOT_HDR_BYTES;
    pos    = cur_hdr + stride * slot;
    pos    = pos + (anywhere ? longint'($urandom_range(0, stride - 1)) : SLOT_HDR_BYTES);
    return OFF_W'(pos);
  endfunction

  // one request; valid stays high for a following request unless a gap comes
  task automatic issue(logic [KIND_W-1:0] kind, logic [OFF_W-1:0] off);
    if (src_gaps && $urandom_range(0, 4) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.kind        <= kind;
    req_ch.slot_offset <= off;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // hold requests until every outstanding result has been taken
  task automatic drain();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_ITEM_BYTES:   cur_item = val;
      REG_SLOTS_IN_USE: begin
        cur_ring = (val[8:0] == 0) ? 1 : ((val[8:0] > MAX_SLOTS) ? MAX_SLOTS : val[8:0]);
      end
      REG_HEADER_BYTES: cur_hdr = val;
      default: ;
    endcase
  endtask

  // registers change only with the block idle; the ring state carries over,
  // so a shrinking ring leaves a stale oldest slot behind
  task automatic configure(logic [15:0] item, logic [8:0] len, logic [15:0] hdr);
    drain();
    write_reg(REG_ITEM_BYTES, item);
    write_reg(REG_SLOTS_IN_USE, {7'($urandom), len});
    write_reg(REG_HEADER_BYTES, hdr);
    // unused register index, should be ignored
    if ($urandom_range(0, 2) == 0) write_reg(REG_RSVD, 16'($urandom));
    cfg_ch.valid <= 1'b0;
  endtask

  // mostly well-formed traffic aimed at the used run, plus some noise
  task automatic random_request();
    int unsigned pick, slot;
    pick = $urandom_range(0, 99);
    if (run_used != 0) begin
      // usually the oldest slot so whole runs get released
      slot = run_oldest;
      if ($urandom_range(0, 2) == 0) slot = slot + $urandom_range(0, run_used - 1);
      slot = slot % cur_ring;
    end else begin
      slot = $urandom_range(0, cur_ring - 1);
    end
    if (pick < 32) begin
      issue(KIND_ALLOC, OFF_W'($urandom));
    end else if (pick < 52) begin
      if ($urandom_range(0, 1) == 0) slot = $urandom_range(0, cur_ring - 1);
      issue(KIND_SHARE, offset_of(slot, 1'($urandom_range(0, 1))));
    end else if (pick < 84) begin
      issue(KIND_DEALLOC, offset_of(slot, 1'($urandom_range(0, 1))));
    end else if (pick < 88) begin
      issue(KIND_W'($urandom), OFF_W'($urandom));
    end else if (pick < 92) begin
      // offset inside the allocator header
      issue(($urandom_range(0, 1) == 0) ? KIND_SHARE : KIND_DEALLOC,
            (cur_hdr == 0) ? '0 : OFF_W'($urandom_range(0, cur_hdr - 1)));
    end else if (pick < 96) begin
      issue(KIND_RSVD, OFF_W'($urandom));
    end else begin
      // slot past the end of the ring
      issue(($urandom_range(0, 1) == 0) ? KIND_SHARE : KIND_DEALLOC,
            offset_of(cur_ring + $urandom_range(0, 7), 1'b1));
    end
  endtask

  initial begin
    rst_n              <= 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.kind        <= KIND_ALLOC;
    req_ch.slot_offset <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.index       <= REG_ITEM_BYTES;
    cfg_ch.data        <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, 68-byte stride behind a 64-byte header
    src_gaps = 1'b0;
    issue(KIND_DEALLOC, offset_of(0, 1'b0));           // empty ring
    issue(KIND_ALLOC, '0);
    issue(KIND_ALLOC, '1);
    issue(KIND_SHARE, OFF_W'(cur_hdr));                 // first byte after the header
    issue(KIND_DEALLOC, '1);                            // far past the ring
    issue(KIND_DEALLOC, OFF_W'(cur_hdr - 1));           // last header byte
    issue(KIND_SHARE, '1);
    issue(KIND_RSVD, '1);
    issue(KIND_RSVD, '0);
    // last slot, last byte
    issue(KIND_SHARE, OFF_W'(offset_of(256, 1'b0) - SLOT_HDR_BYTES - 1));
    issue(KIND_DEALLOC, offset_of(255, 1'b1));          // drops to zero outside the run
    issue(KIND_DEALLOC, offset_of(255, 1'b1));          // clamps at zero
    issue(KIND_DEALLOC, offset_of(0, 1'b1));            // still referenced
    issue(KIND_DEALLOC, offset_of(1, 1'b0));            // releases slots 0 and 1
    issue(KIND_DEALLOC, offset_of(0, 1'b0));            // empty again

    // two-slot ring with zero header and minimum stride; oldest slot is stale
    configure(16'd0, 9'd2, 16'd0);
    issue(KIND_ALLOC, '0);
    issue(KIND_ALLOC, '0);
    issue(KIND_ALLOC, '1);                              // ring full
    issue(KIND_DEALLOC, offset_of(0, 1'b0));
    issue(KIND_DEALLOC, offset_of(1, 1'b0));
    issue(KIND_SHARE, offset_of(2, 1'b0));              // just past the ring

    // count saturation on one slot, then counting it all the way down
    src_gaps = 1'b1;
    configure(16'd16, 9'd3, 16'd32);
    issue(KIND_ALLOC, '0);
    for (int n = 0; n < SAT_SHARES; n++) issue(KIND_SHARE, offset_of(0, 1'b1));
    for (int n = 0; n < SAT_SHARES; n++) issue(KIND_DEALLOC, offset_of(0, 1'b1));

    // random phases over several register settings; the last one runs flat out
    for (int p = 0; p < PHASES; p++) begin
      src_gaps    = (p % 3 != 1) && (p != PHASES - 1);
      sink_stalls = (p % 4 != 2) && (p != PHASES - 1);
      if (p == RANDOM_PHASE) begin
        configure(16'($urandom), 9'($urandom_range(2, 16)), 16'($urandom));
      end else begin
        configure(PHASE_ITEM[p], PHASE_LEN[p], PHASE_HDR[p]);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // now and then let the block run dry before the next request
        if ($urandom_range(0, 99) == 0) drain();
        random_request();
      end
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
